>>> sv/lcg_pkg.sv
// Shared types and constants for the life cellular automaton grid.
// Used by lcg_ctrl, lcg_datapath and life_cellular_automaton_grid.
`default_nettype none
package lcg_pkg;

	localparam int COLS     = 64;
	localparam int ROWS     = 64;
	localparam int COL_W    = $clog2(COLS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int IDX_W    = 12;
	localparam int CNT_W    = $clog2(ROWS + 1);
	localparam int CFG_W    = 7;
	localparam int FUNC_W   = 2;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 8;
	localparam int BORN_CNT = 3;
	localparam int KEEP_LOW = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TOGGLE  = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_ADVANCE = 2'd2,
		FUNC_NOP     = 2'd3
	} func_t;

	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOG_RD,
		S_TOG_WR,
		S_RD_RD,
		S_RD_GET,
		S_ADV,
		S_ADV_END,
		S_FIN
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // take the request, clear result and advance window
		logic rd_en;     // issue a row read
		logic rd_adv;    // read address from the advance counter
		logic adv_step;  // advance counter and feed the row window
		logic tog_wr;    // write back the toggled row
		logic res_load;  // take the addressed bit as result
	} lcg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_last;  // advance counter reached the row past the grid
	} lcg_sts_t;

endpackage
`default_nettype wire

>>> sv/lcg_ctrl.sv
// Sequencer for the life grid: toggle, read and advance operations.
// Depends on lcg_pkg; drives lcg_datapath through lcg_cmd_t.
`default_nettype none
module lcg_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  wire [1:0]            req_func,
	input  wire                  out_free,
	output logic                 out_load,
	output lcg_pkg::lcg_cmd_t    cmd,
	input  lcg_pkg::lcg_sts_t    sts
);
	import lcg_pkg::*;

	state_t state_q, state_nxt;
	logic   accept;

	assign accept = req_valid && req_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func_t'(req_func))
						FUNC_TOGGLE:  state_nxt = S_TOG_RD;
						FUNC_READ:    state_nxt = S_RD_RD;
						FUNC_ADVANCE: state_nxt = S_ADV;
						default:      state_nxt = S_FIN;
					endcase
				end
			end
			S_TOG_RD:  state_nxt = S_TOG_WR;
			S_TOG_WR:  state_nxt = S_FIN;
			S_RD_RD:   state_nxt = S_RD_GET;
			S_RD_GET:  state_nxt = S_FIN;
			S_ADV: begin
				if (sts.cnt_last) begin
					state_nxt = S_ADV_END;
				end
			end
			S_ADV_END: state_nxt = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default:   state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		out_load  = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = accept;
			end
			S_TOG_RD, S_RD_RD: begin
				cmd.rd_en = 1'b1;
			end
			S_TOG_WR: begin
				cmd.tog_wr   = 1'b1;
				cmd.res_load = 1'b1;
			end
			S_RD_GET: begin
				cmd.res_load = 1'b1;
			end
			S_ADV: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_adv   = 1'b1;
				cmd.adv_step = 1'b1;
			end
			S_FIN: begin
				out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_adv_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_func == FUNC_ADVANCE) |=> state_q == S_ADV)
		else $error("advance request did not start the row sweep");

	a_fin_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |-> out_load ##1 state_q == S_IDLE)
		else $error("finished result not handed to the output stage");

	a_tog_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tog_wr |-> $past(state_q) == S_TOG_RD)
		else $error("toggle write without a preceding row read");

endmodule
`default_nettype wire

>>> sv/lcg_datapath.sv
// Datapath of the life grid: row memory, row window, next-generation logic.
// Depends on lcg_pkg; commanded by lcg_ctrl.
`default_nettype none
module lcg_datapath (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	input  wire                       cfg_index,
	input  wire [lcg_pkg::CFG_W-1:0]  cfg_data,
	input  wire [lcg_pkg::IDX_W-1:0]  cell_index,
	input  lcg_pkg::lcg_cmd_t         cmd,
	output lcg_pkg::lcg_sts_t         sts,
	output logic                      cell_alive
);
	import lcg_pkg::*;

	logic [COLS-1:0]  mem [ROWS];
	logic [ROWS-1:0]  row_vld_q;
	logic [COLS-1:0]  rdata_q;
	logic             rvld_q;

	logic [CFG_W-1:0] width_q, height_q, nc, nr;
	logic [COLS-1:0]  col_mask;

	logic [IDX_W-1:0] idx_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             alive_q;

	logic [CNT_W-1:0] cnt_q, k_s1;
	logic             adv_s1;
	logic [COLS-1:0]  above_q, mid_q, below, next_row;

	logic             rd_go;
	logic [ROW_W-1:0] rd_addr;
	logic             wr_en;
	logic [ROW_W-1:0] wr_addr;
	logic [COLS-1:0]  wr_data;
	logic [COLS-1:0]  row_val;
	logic [COLS-1:0]  tog_row;

	assign row_q = idx_q[IDX_W-1:COL_W];
	assign col_q = idx_q[COL_W-1:0];

	assign nc = (width_q  > CFG_W'(COLS)) ? CFG_W'(COLS) : width_q;
	assign nr = (height_q > CFG_W'(ROWS)) ? CFG_W'(ROWS) : height_q;

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			col_mask[c] = CFG_W'(c) < nc;
		end
	end

	assign sts.cnt_last = (cnt_q == CNT_W'(ROWS));

	// rows never written read as dead
	assign row_val = rvld_q ? rdata_q : '0;
	assign tog_row = row_val ^ (COLS'(1) << col_q);

	assign rd_go   = cmd.rd_en && !(cmd.rd_adv && sts.cnt_last);
	assign rd_addr = cmd.rd_adv ? cnt_q[ROW_W-1:0] : row_q;

	// incoming row of the sweep, cut to the used area
	assign below = (adv_s1 && CFG_W'(k_s1) < nr) ? (row_val & col_mask) : '0;

	// B3/S23 over the three-row window, border and unused cells dead
	always_comb begin
		logic [COLS+1:0] pa, pm, pb;
		logic [3:0]      n;
		pa = {1'b0, above_q, 1'b0};
		pm = {1'b0, mid_q,   1'b0};
		pb = {1'b0, below,   1'b0};
		for (int c = 0; c < COLS; c++) begin
			n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2]) + 4'(pm[c]) + 4'(pm[c+2])
				+ 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
			next_row[c] = (n == 4'(BORN_CNT)) || (mid_q[c] && n == 4'(KEEP_LOW));
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_q;
		wr_data = tog_row;
		if (cmd.tog_wr) begin
			wr_en = 1'b1;
		end else if (adv_s1 && k_s1 != '0) begin
			wr_en   = 1'b1;
			wr_addr = ROW_W'(k_s1 - CNT_W'(1));
			wr_data = (CFG_W'(k_s1) <= nr) ? (next_row & col_mask) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_go) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rvld_q    <= 1'b0;
			width_q   <= CFG_W'(COLS);
			height_q  <= CFG_W'(ROWS);
			cnt_q     <= '0;
			adv_s1    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_go) begin
				rvld_q <= row_vld_q[rd_addr];
			end
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default:    width_q  <= width_q;
				endcase
			end
			// hold the counter at the row past the grid once the sweep ends
			if (cmd.capture) begin
				cnt_q <= '0;
			end else if (cmd.adv_step && !sts.cnt_last) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			adv_s1 <= cmd.adv_step;
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= cnt_q;
		if (cmd.capture) begin
			idx_q   <= cell_index;
			alive_q <= 1'b0;
			above_q <= '0;
			mid_q   <= '0;
		end else begin
			if (cmd.res_load) begin
				alive_q <= cmd.tog_wr ? tog_row[col_q] : row_val[col_q];
			end
			if (adv_s1) begin
				above_q <= mid_q;
				mid_q   <= below;
			end
		end
	end

	assign cell_alive = alive_q;

	a_no_raw: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_go && wr_addr == rd_addr))
		else $error("row read and write collide at one address");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ROWS))
		else $error("advance counter ran past the grid");

	a_window_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && k_s1 == '0) |-> (above_q == '0 && mid_q == '0))
		else $error("row window not cleared at sweep start");

endmodule
`default_nettype wire

>>> sv/life_cellular_automaton_grid.sv
// Top level of the life grid (B3/S23 on a 64 x 64 bit array).
// Depends on lcg_pkg, lcg_ctrl and lcg_datapath.
//
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata: toggle a cell, read a cell
//   or advance the used area by one generation. Every request returns one
//   result on m_tvalid/m_tready/m_tdata with the addressed cell's state
//   (0 for an advance or a no-op) and a done flag that is always set.
//   Width and height in use are written on the cfg channel, index 0 for the
//   width, 1 for the height; the user must write them only while no request
//   is in flight, and the block does not enforce this. Values above the grid
//   size saturate to it; zero makes an advance clear the grid.
//   Toggle and read pass through row read, modify or pick, and the result
//   stage. An advance sweeps every row of the grid once through the row
//   memory (one read and one write port), one row per cycle, with a one-row
//   pipeline lag. One request is worked on at a time; the next is accepted
//   as soon as the previous result has moved to the output register, even if
//   the receiver has not taken it yet.
//   Reset: all cells read as dead (per-row valid flags clear at once, no
//   clearing pass), width and height return to 64, the output is empty.
//   A stalled receiver holds the result; a finished request then waits in its
//   last state and no new request is taken until the output frees up.
`default_nettype none
module life_cellular_automaton_grid (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire [lcg_pkg::IN_W-1:0]      s_tdata,   // [1:0] func, [13:2] cell_index
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [lcg_pkg::OUT_W-1:0]    m_tdata,   // [0] cell_alive, [1] done_res
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire                          cfg_index,
	input  wire [lcg_pkg::CFG_W-1:0]     cfg_data
);
	import lcg_pkg::*;

	lcg_cmd_t cmd;
	lcg_sts_t sts;
	logic     out_free;
	logic     out_load;
	logic     cell_alive;
	logic     m_tvalid_q;
	logic     alive_q;

	// registers take writes at any time
	assign cfg_ready = 1'b1;

	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;

	lcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_func  (s_tdata[FUNC_W-1:0]),
		.out_free  (out_free),
		.out_load  (out_load),
		.cmd       (cmd),
		.sts       (sts)
	);

	lcg_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_index (s_tdata[FUNC_W +: IDX_W]),
		.cmd        (cmd),
		.sts        (sts),
		.cell_alive (cell_alive)
	);

	// hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			alive_q <= cell_alive;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_W - 2){1'b0}}, 1'b1, alive_q};

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for life_cellular_automaton_grid: toggle, read and advance
// requests checked against an in-bench B3/S23 grid predictor. Needs lcg_pkg.
module tb;
	import lcg_pkg::*;

	localparam int IDLE_LIMIT   = 3000; // cycles without any handshake
	localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
	localparam int HOLD_AT      = 150;  // result count that starts the hold-off
	localparam int DRAIN_CYCLES = 80;   // above the advance latency
	localparam int PHASE_ITEMS  = 50;

	typedef struct {
		func_t            fn;
		logic [IDX_W-1:0] idx;
	} grid_req_t;

	typedef struct {
		logic alive;
		logic done;
	} cell_result_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;   // [1:0] func, [13:2] cell_index
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;          // [0] cell_alive, [1] done_res
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	cfg_idx_t         cfg_index = CFG_WIDTH;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Requests waiting for the driver, and results the grid owes us.
	grid_req_t    pending_reqs[$];
	cell_result_t expected_cells[$];
	grid_req_t    cur_req;
	cell_result_t rx_want;

	// Predicted grid contents and the size registers as last written.
	logic [COLS-1:0]  grid_state [ROWS];
	logic [CFG_W-1:0] used_width  = 7'd64;
	logic [CFG_W-1:0] used_height = 7'd64;

	int errors      = 0;
	int n_checked   = 0;
	int n_settings  = 0;
	int idle_cycles = 0;
	int n_by_func [4] = '{default: 0};
	int tx_wait = 0, tx_run = 0, rx_wait = 0, rx_run = 0, hold_left = 0;
	bit tx_quiet = 1'b0, rx_quiet = 1'b0;

	life_cellular_automaton_grid dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// One B3/S23 generation over the used area; everything else ends up dead
	// and counts as dead for its neighbours, as does the outer border.
	function automatic void next_generation();
		logic [COLS-1:0] nxt [ROWS];
		int nr, nc, n, r, c, dr, dc, rr, cc;
		nr = (used_height > ROWS) ? ROWS : used_height;
		nc = (used_width > COLS) ? COLS : used_width;
		for (r = 0; r < ROWS; r++)
			nxt[r] = '0;
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				n = 0;
				for (dr = -1; dr <= 1; dr++) begin
					for (dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
							n += grid_state[rr][cc];
					end
				end
				// a dead cell is born only on exactly three, never kept
				if (grid_state[r][c])
					nxt[r][c] = (n == KEEP_LOW || n == BORN_CNT);
				else
					nxt[r][c] = (n == BORN_CNT);
			end
		end
		grid_state = nxt;
	endfunction

	// Apply one request to the predicted grid and return the result it owes.
	function automatic cell_result_t apply_request(grid_req_t req);
		cell_result_t res;
		int row, col;
		row = req.idx / COLS;
		col = req.idx % COLS;
		res.alive = 1'b0;
		res.done  = 1'b1;
		case (req.fn)
			FUNC_TOGGLE: begin
				if (row < ROWS) begin
					grid_state[row][col] = ~grid_state[row][col];
					res.alive = grid_state[row][col];
				end
			end
			FUNC_READ: begin
				if (row < ROWS)
					res.alive = grid_state[row][col];
			end
			FUNC_ADVANCE: begin
				next_generation();
			end
			default: begin
				// no-op: grid untouched, cell_alive stays 0
			end
		endcase
		return res;
	endfunction

	// Per-request random wait, with runs of back-to-back traffic.
	function automatic int draw_wait(ref int run_left, ref bit no_gaps);
		if (run_left == 0) begin
			run_left = $urandom_range(5, 40);
			no_gaps  = ($urandom_range(0, 3) == 0);
		end
		run_left--;
		return no_gaps ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic void queue_req(func_t fn, int row, int col);
		grid_req_t req;
		req.fn  = fn;
		req.idx = IDX_W'(row * COLS + col);
		pending_reqs.push_back(req);
	endfunction

	// Driver: present queued requests, predict each one at its handshake.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_cells.push_back(apply_request(cur_req));
				n_by_func[cur_req.fn]++;
				tx_wait = draw_wait(tx_run, tx_quiet);
			end
			// hold an offered request until it is taken
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					s_tdata  <= IN_W'({cur_req.idx, cur_req.fn});
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result against the oldest expectation, stall at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_cells.size() == 0) begin
					$display("%0t: unexpected result, expected none, got data %h", $time, m_tdata);
					errors++;
				end else begin
					rx_want = expected_cells.pop_front();
					if (m_tdata[0] !== rx_want.alive) begin
						$display("%0t: cell_alive mismatch, expected %0b, got %0b",
							$time, rx_want.alive, m_tdata[0]);
						errors++;
					end
					if (m_tdata[1] !== rx_want.done) begin
						$display("%0t: done_res mismatch, expected %0b, got %0b",
							$time, rx_want.done, m_tdata[1]);
						errors++;
					end
				end
				n_checked++;
				rx_wait = draw_wait(rx_run, rx_quiet);
				// back the grid up once: output held, input must stall
				if (n_checked == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if no handshake of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles, %0d results outstanding",
					$time, idle_cycles, expected_cells.size());
				$display("** life_cellular_automaton_grid: FAILED **");
				$finish;
			end
		end
	end

	// Write one size register; only called with no request in flight.
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_WIDTH)
			used_width = val;
		else
			used_height = val;
	endtask

	task automatic set_grid_size(int w, int h);
		write_reg(CFG_WIDTH, CFG_W'(w));
		write_reg(CFG_HEIGHT, CFG_W'(h));
		n_settings++;
	endtask

	// Pause the sender until every queued request has been answered.
	task automatic wait_quiet();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_cells.size() != 0);
	endtask

	// Random traffic: mostly toggles and reads inside the used area with
	// advances mixed in so patterns evolve; some requests land anywhere.
	task automatic random_phase(int count);
		int kind, nr, nc;
		func_t fn;
		nr = (used_height > ROWS) ? ROWS : used_height;
		nc = (used_width > COLS) ? COLS : used_width;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 40)
				fn = FUNC_TOGGLE;
			else if (kind < 72)
				fn = FUNC_READ;
			else if (kind < 94)
				fn = FUNC_ADVANCE;
			else
				fn = FUNC_NOP;
			if (nr > 0 && nc > 0 && $urandom_range(0, 99) < 85)
				queue_req(fn, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
			else
				queue_req(fn, $urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
		end
	endtask

	initial begin
		int sizes_w [9] = '{1, 64, 127, 3, 6, 0, 20, 64, 2};
		int sizes_h [9] = '{1, 64, 127, 4, 9, 12, 2, 1, 64};
		foreach (grid_state[r])
			grid_state[r] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full 64 x 64 grid after reset: corners, no-op, lonely cells, blinker.
		queue_req(FUNC_READ, 0, 0);
		queue_req(FUNC_READ, ROWS - 1, COLS - 1);
		queue_req(FUNC_TOGGLE, 0, 0);
		queue_req(FUNC_TOGGLE, ROWS - 1, COLS - 1);
		queue_req(FUNC_TOGGLE, 0, COLS - 1);
		queue_req(FUNC_TOGGLE, ROWS - 1, 0);
		queue_req(FUNC_NOP, ROWS - 1, COLS - 1);
		queue_req(FUNC_TOGGLE, 10, 20);
		queue_req(FUNC_TOGGLE, 10, 21);
		queue_req(FUNC_TOGGLE, 10, 22);
		queue_req(FUNC_ADVANCE, 0, 0);
		queue_req(FUNC_READ, 9, 21);
		queue_req(FUNC_READ, 10, 20);
		queue_req(FUNC_READ, 0, 0);
		queue_req(FUNC_ADVANCE, ROWS - 1, COLS - 1);
		queue_req(FUNC_READ, 10, 20);
		queue_req(FUNC_TOGGLE, 0, 0);
		queue_req(FUNC_TOGGLE, 0, 0);
		wait_quiet();

		// Zero width: no cell takes part, an advance clears a stable block.
		set_grid_size(0, 64);
		@(negedge clk);
		queue_req(FUNC_TOGGLE, 1, 1);
		queue_req(FUNC_TOGGLE, 1, 2);
		queue_req(FUNC_TOGGLE, 2, 1);
		queue_req(FUNC_TOGGLE, 2, 2);
		queue_req(FUNC_ADVANCE, 0, 0);
		queue_req(FUNC_READ, 1, 1);
		wait_quiet();

		// Oversized registers saturate: a block in the far corner survives.
		set_grid_size(127, 65);
		@(negedge clk);
		queue_req(FUNC_TOGGLE, ROWS - 2, COLS - 2);
		queue_req(FUNC_TOGGLE, ROWS - 2, COLS - 1);
		queue_req(FUNC_TOGGLE, ROWS - 1, COLS - 2);
		queue_req(FUNC_TOGGLE, ROWS - 1, COLS - 1);
		queue_req(FUNC_ADVANCE, 0, 0);
		queue_req(FUNC_READ, ROWS - 1, COLS - 1);
		wait_quiet();

		// 5 x 5: blinker on the right edge is clipped, cells outside die.
		set_grid_size(5, 5);
		@(negedge clk);
		queue_req(FUNC_TOGGLE, 1, 4);
		queue_req(FUNC_TOGGLE, 2, 4);
		queue_req(FUNC_TOGGLE, 3, 4);
		queue_req(FUNC_TOGGLE, 0, 10);
		queue_req(FUNC_READ, 0, 10);
		queue_req(FUNC_ADVANCE, 0, 0);
		queue_req(FUNC_READ, 2, 3);
		queue_req(FUNC_READ, 2, 5);
		queue_req(FUNC_READ, 0, 10);
		queue_req(FUNC_READ, ROWS - 1, COLS - 1);
		wait_quiet();

		// Random phases over fixed sizes, then a couple of random sizes.
		for (int p = 0; p < 11; p++) begin
			if (p < 9)
				set_grid_size(sizes_w[p], sizes_h[p]);
			else
				set_grid_size($urandom_range(0, 127), $urandom_range(0, 127));
			@(negedge clk);
			random_phase(PHASE_ITEMS);
			wait_quiet();
		end

		// Let any stray result show up before judging.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_cells.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_cells.size());
			errors++;
		end
		$display("Sent %0d toggles, %0d reads, %0d advances, %0d no-ops over %0d grid sizes;",
			n_by_func[FUNC_TOGGLE], n_by_func[FUNC_READ], n_by_func[FUNC_ADVANCE],
			n_by_func[FUNC_NOP], n_settings);
		$display("checked %0d results, %0d errors, with one %0d-cycle output stall.",
			n_checked, errors, HOLD_CYCLES);
		if (errors == 0)
			$display("** life_cellular_automaton_grid: PASSED **");
		else
			$display("** life_cellular_automaton_grid: FAILED **");
		$finish;
	end

endmodule
